// ----- design/jsu_pkg.sv -----
package jsu_pkg;

  // Default number of decoded commands held between front and back
  localparam int QUEUE_DEPTH = 4;

  // Result kinds as seen on the output channel
  typedef enum logic [1:0] {
    KIND_DATA = 2'd0,
    KIND_DONE = 2'd1,
    KIND_ERR  = 2'd2
  } kind_t;

  // One decoded command: up to four result words, bytes[0] goes out first
  typedef struct packed {
    kind_t           kind;
    logic [1:0]      last_idx;
    logic [3:0][7:0] bytes;
  } cmd_t;

  // Characters with a meaning of their own
  localparam logic [7:0] CHAR_QUOTE  = 8'h22;
  localparam logic [7:0] CHAR_BSLASH = 8'h5C;
  localparam logic [7:0] CHAR_SLASH  = 8'h2F;
  localparam logic [7:0] CHAR_SPACE  = 8'h20;
  localparam logic [7:0] CHAR_U      = 8'h75;
  localparam logic [7:0] CHAR_B      = 8'h62;
  localparam logic [7:0] CHAR_F      = 8'h66;
  localparam logic [7:0] CHAR_N      = 8'h6E;
  localparam logic [7:0] CHAR_R      = 8'h72;
  localparam logic [7:0] CHAR_T      = 8'h74;

  // Surrogate ranges
  localparam logic [15:0] HIGH_SUR_LO = 16'hD800;
  localparam logic [15:0] HIGH_SUR_HI = 16'hDBFF;
  localparam logic [15:0] LOW_SUR_LO  = 16'hDC00;
  localparam logic [15:0] LOW_SUR_HI  = 16'hDFFF;
  localparam logic [20:0] SUPP_BASE   = 21'h10000;

  // Decode one hex digit, either case: {valid, value}
  function automatic logic [4:0] hex_nibble(input logic [7:0] c);
    logic [4:0] r;
    r = '0;
    if (c inside {[8'h30:8'h39]}) begin
      r = {1'b1, c[3:0]};
    end else if (c inside {[8'h41:8'h46], [8'h61:8'h66]}) begin
      r = {1'b1, c[3:0] + 4'd9};
    end
    return r;
  endfunction

  // Build a command that gives a single result word
  function automatic cmd_t single_cmd(input kind_t kind, input logic [7:0] b);
    cmd_t c;
    c = '0;
    c.kind = kind;
    c.bytes[0] = b;
    return c;
  endfunction

  // Encode a code point as one to four UTF-8 bytes
  function automatic cmd_t utf8_cmd(input logic [20:0] cp);
    cmd_t c;
    c = '0;
    c.kind = KIND_DATA;
    if (cp <= 21'h7F) begin
      c.bytes[0] = cp[7:0];
      c.last_idx = 2'd0;
    end else if (cp <= 21'h7FF) begin
      c.bytes[0] = 8'hC0 | {3'b000, cp[10:6]};
      c.bytes[1] = 8'h80 | {2'b00, cp[5:0]};
      c.last_idx = 2'd1;
    end else if (cp <= 21'hFFFF) begin
      c.bytes[0] = 8'hE0 | {4'b0000, cp[15:12]};
      c.bytes[1] = 8'h80 | {2'b00, cp[11:6]};
      c.bytes[2] = 8'h80 | {2'b00, cp[5:0]};
      c.last_idx = 2'd2;
    end else begin
      c.bytes[0] = 8'hF0 | {5'b00000, cp[20:18]};
      c.bytes[1] = 8'h80 | {2'b00, cp[17:12]};
      c.bytes[2] = 8'h80 | {2'b00, cp[11:6]};
      c.bytes[3] = 8'h80 | {2'b00, cp[5:0]};
      c.last_idx = 2'd3;
    end
    return c;
  endfunction

endpackage

// ----- design/jsu_in_if.sv -----
interface jsu_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       end_of_text;

  modport source (output valid, output in_byte, output end_of_text, input ready);
  modport sink (input valid, input in_byte, input end_of_text, output ready);
endinterface

// ----- design/jsu_out_if.sv -----
interface jsu_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic [1:0] kind;
  logic       last_of_run;

  modport source (output valid, output out_byte, output kind, output last_of_run,
                  input ready);
  modport sink (input valid, input out_byte, input kind, input last_of_run,
                output ready);
endinterface

// ----- design/json_string_unescaper_unit.sv -----
// A result word passes from the parser through the command queue and then the emitter's output register.
// Throughput: one input word per cycle unless the queue is full; a \u escape emits 1 to 4 result
//   words, one per cycle while the sink is ready; up to QueueDepth decoded commands wait in the queue.
// Input ready drops only while that queue is full; the emitter's output register decouples sinks.
// Reset (rst, synchronous, active high): parser waits for an opening quote, queue and output empty.
module json_string_unescaper_unit #(
  parameter int QueueDepth = jsu_pkg::QUEUE_DEPTH
) (
  input logic       clk,
  input logic       rst,
  jsu_in_if.sink    text,
  jsu_out_if.source result
);

  logic          q_full;
  logic          push;
  jsu_pkg::cmd_t push_cmd;
  logic          pop;
  logic          head_valid;
  jsu_pkg::cmd_t head;

  jsu_front u_front (
    .clk      (clk),
    .rst      (rst),
    .text     (text),
    .q_full   (q_full),
    .push     (push),
    .push_cmd (push_cmd)
  );

  jsu_queue #(.Depth(QueueDepth)) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_cmd   (push_cmd),
    .pop        (pop),
    .full       (q_full),
    .head_valid (head_valid),
    .head       (head)
  );

  jsu_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head_valid (head_valid),
    .head       (head),
    .pop        (pop),
    .result     (result)
  );

endmodule

// ----- design/jsu_front.sv -----
module jsu_front (
  input  logic          clk,
  input  logic          rst,
  jsu_in_if.sink        text,
  input  logic          q_full,
  output logic          push,
  output jsu_pkg::cmd_t push_cmd
);

  typedef enum logic [2:0] {
    PH_WAIT = 3'd0,
    PH_STR  = 3'd1,
    PH_ESC  = 3'd2,
    PH_HEX  = 3'd3,
    PH_LBS  = 3'd4,
    PH_LU   = 3'd5,
    PH_LHEX = 3'd6
  } phase_t;

  phase_t      phase, phase_next;
  logic [1:0]  hex_count, hex_count_next;
  logic [15:0] code_accum, code_accum_next;
  logic [9:0]  high_half, high_half_next;

  logic          accept;
  logic          fail;
  logic          emit;
  logic [7:0]    b;
  logic [4:0]    hex;
  jsu_pkg::cmd_t cmd;

  assign text.ready = !q_full;
  assign accept = text.valid && text.ready;
  assign b = text.in_byte;
  assign hex = jsu_pkg::hex_nibble(b);

  // Classify the word against the current phase
  always_comb begin
    phase_next = phase;
    hex_count_next = hex_count;
    code_accum_next = code_accum;
    high_half_next = high_half;
    fail = 1'b0;
    emit = 1'b0;
    cmd = jsu_pkg::single_cmd(jsu_pkg::KIND_DATA, b);
    if (text.end_of_text) begin
      fail = 1'b1;
    end else begin
      case (phase)
        PH_STR: begin
          if (b < jsu_pkg::CHAR_SPACE) begin
            fail = 1'b1;
          end else if (b == jsu_pkg::CHAR_QUOTE) begin
            emit = 1'b1;
            cmd = jsu_pkg::single_cmd(jsu_pkg::KIND_DONE, 8'h00);
            phase_next = PH_WAIT;
          end else if (b == jsu_pkg::CHAR_BSLASH) begin
            phase_next = PH_ESC;
          end else begin
            emit = 1'b1;
          end
        end
        PH_ESC: begin
          phase_next = PH_STR;
          emit = 1'b1;
          case (b)
            jsu_pkg::CHAR_QUOTE, jsu_pkg::CHAR_BSLASH, jsu_pkg::CHAR_SLASH: ;
            jsu_pkg::CHAR_B: cmd = jsu_pkg::single_cmd(jsu_pkg::KIND_DATA, 8'h08);
            jsu_pkg::CHAR_F: cmd = jsu_pkg::single_cmd(jsu_pkg::KIND_DATA, 8'h0C);
            jsu_pkg::CHAR_N: cmd = jsu_pkg::single_cmd(jsu_pkg::KIND_DATA, 8'h0A);
            jsu_pkg::CHAR_R: cmd = jsu_pkg::single_cmd(jsu_pkg::KIND_DATA, 8'h0D);
            jsu_pkg::CHAR_T: cmd = jsu_pkg::single_cmd(jsu_pkg::KIND_DATA, 8'h09);
            jsu_pkg::CHAR_U: begin
              emit = 1'b0;
              phase_next = PH_HEX;
              hex_count_next = 2'd0;
              code_accum_next = 16'h0000;
            end
            default: begin
              emit = 1'b0;
              fail = 1'b1;
            end
          endcase
        end
        PH_HEX, PH_LHEX: begin
          if (!hex[4]) begin
            fail = 1'b1;
          end else begin
            code_accum_next = {code_accum[11:0], hex[3:0]};
            if (hex_count != 2'd3) begin
              hex_count_next = hex_count + 2'd1;
            end else begin
              hex_count_next = 2'd0;
              if (phase == PH_HEX) begin
                if (code_accum_next >= jsu_pkg::HIGH_SUR_LO &&
                    code_accum_next <= jsu_pkg::HIGH_SUR_HI) begin
                  high_half_next = code_accum_next[9:0];
                  phase_next = PH_LBS;
                end else if (code_accum_next >= jsu_pkg::LOW_SUR_LO &&
                             code_accum_next <= jsu_pkg::LOW_SUR_HI) begin
                  fail = 1'b1;
                end else begin
                  emit = 1'b1;
                  cmd = jsu_pkg::utf8_cmd({5'b00000, code_accum_next});
                  phase_next = PH_STR;
                end
              end else begin
                if (code_accum_next < jsu_pkg::LOW_SUR_LO ||
                    code_accum_next > jsu_pkg::LOW_SUR_HI) begin
                  fail = 1'b1;
                end else begin
                  emit = 1'b1;
                  cmd = jsu_pkg::utf8_cmd(jsu_pkg::SUPP_BASE +
                                          {1'b0, high_half, code_accum_next[9:0]});
                  phase_next = PH_STR;
                end
              end
            end
          end
        end
        PH_LBS: begin
          if (b == jsu_pkg::CHAR_BSLASH) phase_next = PH_LU;
          else fail = 1'b1;
        end
        PH_LU: begin
          if (b == jsu_pkg::CHAR_U) begin
            phase_next = PH_LHEX;
            hex_count_next = 2'd0;
            code_accum_next = 16'h0000;
          end else begin
            fail = 1'b1;
          end
        end
        default: begin
          if (b == jsu_pkg::CHAR_QUOTE) begin
            phase_next = PH_STR;
          end else if (!(b inside {[8'h09:8'h0D], jsu_pkg::CHAR_SPACE})) begin
            fail = 1'b1;
          end
        end
      endcase
    end
    // Drop back to waiting on any failure
    if (fail) begin
      emit = 1'b1;
      cmd = jsu_pkg::single_cmd(jsu_pkg::KIND_ERR, 8'h00);
      phase_next = PH_WAIT;
      hex_count_next = 2'd0;
      code_accum_next = 16'h0000;
    end
  end

  assign push = accept && emit;
  assign push_cmd = cmd;

  // Advance parser state on each accepted word
  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_WAIT;
      hex_count <= 2'd0;
      code_accum <= 16'h0000;
      high_half <= 10'd0;
    end else if (accept) begin
      phase <= phase_next;
      hex_count <= hex_count_next;
      code_accum <= code_accum_next;
      high_half <= high_half_next;
    end
  end

endmodule

// ----- design/jsu_queue.sv -----
module jsu_queue #(
  parameter int Depth = jsu_pkg::QUEUE_DEPTH
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  jsu_pkg::cmd_t push_cmd,
  input  logic          pop,
  output logic          full,
  output logic          head_valid,
  output jsu_pkg::cmd_t head
);

  localparam int PtrW = $clog2(Depth);
  localparam int CntW = $clog2(Depth + 1);

  jsu_pkg::cmd_t entries [Depth];
  logic [PtrW-1:0] wr_ptr;
  logic [PtrW-1:0] rd_ptr;
  logic [CntW-1:0] count;

  assign full = (count == CntW'(Depth));
  assign head_valid = (count != '0);
  assign head = entries[rd_ptr];

  // Store pushed commands
  always_ff @(posedge clk) begin
    if (push) entries[wr_ptr] <= push_cmd;
  end

  // Advance pointers and occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count <= '0;
    end else begin
      if (push) wr_ptr <= (wr_ptr == PtrW'(Depth - 1)) ? '0 : wr_ptr + 1'b1;
      if (pop) rd_ptr <= (rd_ptr == PtrW'(Depth - 1)) ? '0 : rd_ptr + 1'b1;
      if (push && !pop) count <= count + 1'b1;
      else if (pop && !push) count <= count - 1'b1;
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    full |-> !push)
    else $error("command pushed into full queue");

  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    pop |-> head_valid)
    else $error("command popped from empty queue");

endmodule

// ----- design/jsu_back.sv -----
module jsu_back (
  input  logic          clk,
  input  logic          rst,
  input  logic          head_valid,
  input  jsu_pkg::cmd_t head,
  output logic          pop,
  jsu_out_if.source     result
);

  logic [1:0] idx;
  logic       load;
  logic       at_last;

  assign load = head_valid && (!result.valid || result.ready);
  assign at_last = (idx == head.last_idx);
  assign pop = load && at_last;

  // Load the next word of the head command into the output register
  always_ff @(posedge clk) begin
    if (rst) begin
      result.valid <= 1'b0;
      idx <= 2'd0;
    end else begin
      if (load) begin
        result.valid <= 1'b1;
        idx <= at_last ? 2'd0 : idx + 2'd1;
      end else if (result.ready) begin
        result.valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      result.out_byte <= head.bytes[idx];
      result.kind <= head.kind;
      result.last_of_run <= at_last;
    end
  end

  a_status_is_last: assert property (@(posedge clk) disable iff (rst)
    result.valid && result.kind != jsu_pkg::KIND_DATA |-> result.last_of_run)
    else $error("done or error word not marked last");

  a_idx_in_range: assert property (@(posedge clk) disable iff (rst)
    head_valid |-> idx <= head.last_idx)
    else $error("word index past end of command");

endmodule
